### hw/rtl/plid_pkg.sv
// Shared types, constants and controller/datapath interface for the positional list unit.
package plid_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int INDEX_W   = 9;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 9;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                      kind;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]         count;
    } out_item_t;

    typedef struct packed {
        logic    load;
        logic    setup;
        logic    shift_step;
        logic    commit_ins;
        logic    commit_rem;
        logic    read_issue;
        logic    capture;
        logic    out_load;
        status_t status;
    } plid_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  bad_pos;
        logic  shift_done;
    } plid_stat_t;

endpackage

### hw/rtl/positional_list_insert_delete_unit.sv
// Top level of the positional list unit: ordered store with insert, remove and read.
//
// Usage: s_valid/s_ready/s_data carries one operation per transfer (insert, remove
// or read at a position); m_valid/m_ready/m_data returns exactly one result per
// operation with status, read value and the element count afterwards.
// Operations are handled one at a time. Insert and remove move every element
// behind the position through the element RAM, one element per cycle, before
// the commit; a read goes through the RAM's registered read port, and a refused
// insert, an out-of-range position or an unused kind posts its result straight
// from the decision. Up to DEPTH - 1 moves per operation. The RAM's single read
// port and single write port set that rate. The next operation is taken in the
// cycle after the result is posted.
// The result sits in an output register: a new operation is taken while the
// previous result still waits, and a stalled receiver holds the unit only
// when the next result is ready to be posted.
// Reset (aresetn low, synchronous) empties the list and clears m_valid;
// the element RAM is not cleared, as only entries below the count are read.
module positional_list_insert_delete_unit
    import plid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    plid_cmd_t  cmd;
    plid_stat_t stat;

    plid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    plid_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("operation accepted while another is in progress");

    a_value_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_DONE)) |-> (m_data.read_value == '0))
        else $error("nonzero read value on a rejected operation");

    a_commit_after_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit_ins || cmd.commit_rem) |-> stat.shift_done)
        else $error("commit while element moves are outstanding");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result register load lost");
`endif

endmodule

### hw/rtl/plid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/plid_datapath.sv
// Datapath: element memory, count, shift pointers and result register.
module plid_datapath
    import plid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  plid_cmd_t  cmd,
    output plid_stat_t stat,
    output out_item_t  m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;

    kind_t                 kind_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         rem_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic [AW-1:0]         wr_ptr_reg;
    logic                  pend_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    out_item_t             m_data_reg;

    logic [WW-1:0]         idx_w;
    logic [WW-1:0]         cnt_w;
    logic [WW-1:0]         pos_w;
    logic [WW-1:0]         idx_m1;
    logic [CW-1:0]         cnt_m1;
    logic                  move;
    logic                  is_ins;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [VALUE_W-1:0]    ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [VALUE_W-1:0]    ram_rd_data;

    assign idx_w  = WW'(idx_reg);
    assign cnt_w  = WW'(count_reg);
    assign pos_w  = (idx_w > cnt_w) ? cnt_w : idx_w;
    assign idx_m1 = idx_w - WW'(1);
    assign cnt_m1 = count_reg - CW'(1);
    assign is_ins = (kind_reg == KIND_INSERT);
    assign move   = cmd.shift_step && (rem_reg != '0);

    assign stat.kind       = kind_reg;
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.bad_pos    = (idx_w == '0) || (idx_w > cnt_w);
    assign stat.shift_done = (rem_reg == '0) && !pend_reg;

    always_comb begin
        ram_wr_en   = pend_reg || cmd.commit_ins;
        ram_wr_addr = pend_reg ? wr_ptr_reg : pos_reg[AW-1:0];
        ram_wr_data = pend_reg ? ram_rd_data : value_reg;
        ram_rd_en   = move || cmd.read_issue;
        ram_rd_addr = cmd.read_issue ? idx_m1[AW-1:0] : rd_ptr_reg;
    end

    plid_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= move;
            if (cmd.setup) begin
                if (is_ins) begin
                    rem_reg <= count_reg - pos_w[CW-1:0];
                end else begin
                    rem_reg <= count_reg - idx_w[CW-1:0];
                end
            end else if (move) begin
                rem_reg <= rem_reg - CW'(1);
            end
            if (cmd.commit_ins) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.commit_rem) begin
                count_reg <= cnt_m1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg      <= s_data.kind;
            idx_reg       <= s_data.index;
            value_reg     <= s_data.value;
            res_value_reg <= '0;
        end
        if (cmd.setup) begin
            pos_reg <= pos_w[CW-1:0];
            if (is_ins) begin
                rd_ptr_reg <= cnt_m1[AW-1:0];
            end else begin
                rd_ptr_reg <= idx_w[AW-1:0];
            end
        end else if (move) begin
            if (is_ins) begin
                wr_ptr_reg <= rd_ptr_reg + AW'(1);
                rd_ptr_reg <= rd_ptr_reg - AW'(1);
            end else begin
                wr_ptr_reg <= rd_ptr_reg - AW'(1);
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
        end
        if (cmd.capture) begin
            res_value_reg <= ram_rd_data;
        end
        if (cmd.out_load) begin
            m_data_reg.status     <= cmd.status;
            m_data_reg.read_value <= res_value_reg;
            m_data_reg.count      <= cnt_w[COUNT_W-1:0];
        end
    end

    assign m_data = m_data_reg;

endmodule

### hw/rtl/plid_ctrl.sv
// Controller: sequences accept, shift, commit, read and result transfer.
module plid_ctrl
    import plid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  plid_stat_t stat,
    output plid_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_COMMIT,
        S_READ,
        S_CAPTURE,
        S_RESULT
    } state_t;

    state_t  state_reg;
    logic    m_valid_reg;
    status_t status_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.load       = s_valid && s_ready;
        cmd.setup      = (state_reg == S_DECIDE);
        cmd.shift_step = (state_reg == S_SHIFT);
        cmd.commit_ins = (state_reg == S_COMMIT) && (stat.kind == KIND_INSERT);
        cmd.commit_rem = (state_reg == S_COMMIT) && (stat.kind == KIND_REMOVE);
        cmd.read_issue = (state_reg == S_READ);
        cmd.capture    = (state_reg == S_CAPTURE);
        cmd.out_load   = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);
        cmd.status     = status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_DONE;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd.load) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    unique case (stat.kind)
                        KIND_INSERT: begin
                            status_reg <= stat.full ? ST_FULL : ST_DONE;
                            state_reg  <= stat.full ? S_RESULT : S_SHIFT;
                        end
                        KIND_REMOVE: begin
                            status_reg <= stat.bad_pos ? ST_RANGE : ST_DONE;
                            state_reg  <= stat.bad_pos ? S_RESULT : S_SHIFT;
                        end
                        KIND_READ: begin
                            status_reg <= stat.bad_pos ? ST_RANGE : ST_DONE;
                            state_reg  <= stat.bad_pos ? S_RESULT : S_READ;
                        end
                        default: begin
                            status_reg <= ST_DONE;
                            state_reg  <= S_RESULT;
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (stat.shift_done) begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    state_reg <= S_RESULT;
                end
                S_READ: begin
                    state_reg <= S_CAPTURE;
                end
                S_CAPTURE: begin
                    state_reg <= S_RESULT;
                end
                S_RESULT: begin
                    if (cmd.out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
